// ===== hw/rtl/msfps_pkg.sv =====
// ----------------------------------------------------------------------------
// msfps_pkg
// shared constants and codes for the subset fraction product search
// ----------------------------------------------------------------------------
package msfps_pkg;

    localparam int MAX_ITEMS_DEF   = 8;
    localparam int VALUE_WIDTH_DEF = 12;

    // product magnitudes are kept below 2^63
    localparam int MAG_W    = 63;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND = 2'd0,
        ST_NONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_NUM = 1'b0,
        REG_TARGET_DEN = 1'b1
    } cfg_reg_t;

endpackage

// ===== hw/rtl/msfps_if.sv =====
// ----------------------------------------------------------------------------
// msfps channel interfaces
// item, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface msfps_in_if #(
    parameter int W = msfps_pkg::VALUE_WIDTH_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] numerator;
    logic [W-1:0] denominator;
    logic         final_item;

    modport source (output valid, numerator, denominator, final_item, input ready);
    modport sink   (input valid, numerator, denominator, final_item, output ready);
endinterface

interface msfps_out_if #(
    parameter int W = msfps_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [W-1:0]                  out_numerator;
    logic [W-1:0]                  out_denominator;
    logic [msfps_pkg::STATUS_W-1:0] status;
    logic                          last_result;

    modport source (output valid, out_numerator, out_denominator, status, last_result,
                    input ready);
    modport sink   (input valid, out_numerator, out_denominator, status, last_result,
                    output ready);
endinterface

interface msfps_cfg_if #(
    parameter int W = msfps_pkg::VALUE_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [msfps_pkg::CFG_IDX_W-1:0] index;
    logic [W-1:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/msfps_ram.sv =====
// ----------------------------------------------------------------------------
// msfps_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module msfps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/msfps_mul.sv =====
// ----------------------------------------------------------------------------
// msfps_mul
// 63 by BW bit unsigned multiply from two partial products, split at bit 32 of a
// ----------------------------------------------------------------------------
module msfps_mul #(
    parameter int BW = msfps_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [msfps_pkg::MAG_W-1:0]   a,
    input  logic [BW-1:0]                 b,
    output logic                          done,
    output logic [msfps_pkg::MAG_W+BW-1:0] p
);

    localparam int MW = msfps_pkg::MAG_W;
    localparam int PW = MW + BW;

    typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SUM} mstate_t;

    mstate_t          state_reg;
    logic [MW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;
    logic [32+BW-1:0] lo_reg;
    logic [MW-32+BW-1:0] hi_reg;
    logic [PW-1:0]    p_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a;
                        b_reg     <= b;
                        state_reg <= M_LO;
                    end
                end
                M_LO:
                begin
                    lo_reg    <= a_reg[31:0] * b_reg;
                    state_reg <= M_HI;
                end
                M_HI:
                begin
                    hi_reg    <= a_reg[MW-1:32] * b_reg;
                    state_reg <= M_SUM;
                end
                M_SUM:
                begin
                    p_reg     <= (PW'(hi_reg) << 32) + PW'(lo_reg);
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// ===== hw/rtl/msfps_red.sv =====
// ----------------------------------------------------------------------------
// msfps_red
// fraction reduction: binary gcd then two parallel restoring divisions
// ----------------------------------------------------------------------------
module msfps_red (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [msfps_pkg::MAG_W-1:0] num,
    input  logic [msfps_pkg::MAG_W-1:0] den,
    output logic                        done,
    output logic [msfps_pkg::MAG_W-1:0] rnum,
    output logic [msfps_pkg::MAG_W-1:0] rden
);

    localparam int MW = msfps_pkg::MAG_W;
    localparam int KW = $clog2(MW);

    typedef enum logic [1:0] {R_IDLE, R_TWOS, R_GCD, R_DIV} rstate_t;

    rstate_t       state_reg;
    logic [MW-1:0] n_reg, d_reg, u_reg, v_reg;
    logic [MW-1:0] qn_reg, qd_reg, rn_reg, rd_reg;
    logic [KW-1:0] k_reg, cnt_reg;
    logic          done_reg;

    logic [MW:0]   tn, td;
    logic          gen, ged;

    always_comb
    begin
        tn  = {rn_reg, qn_reg[MW-1]};
        td  = {rd_reg, qd_reg[MW-1]};
        gen = tn >= {1'b0, u_reg};
        ged = td >= {1'b0, u_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        n_reg <= num;
                        d_reg <= den;
                        u_reg <= num;
                        v_reg <= den;
                        k_reg <= '0;
                        if (num == '0)
                        begin
                            // zero numerator reduces to 0/1
                            qn_reg   <= '0;
                            qd_reg   <= MW'(1);
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= R_TWOS;
                        end
                    end
                end
                R_TWOS:
                begin
                    if (!u_reg[0] && !v_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= R_GCD;
                    end
                end
                R_GCD:
                begin
                    priority if (!u_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_reg <= v_reg >> 1;
                    end
                    else if (u_reg == v_reg)
                    begin
                        // odd part of the gcd is in u, power of two in k
                        qn_reg    <= n_reg >> k_reg;
                        qd_reg    <= d_reg >> k_reg;
                        rn_reg    <= '0;
                        rd_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= R_DIV;
                    end
                    else if (u_reg > v_reg)
                    begin
                        u_reg <= u_reg - v_reg;
                    end
                    else
                    begin
                        v_reg <= v_reg - u_reg;
                    end
                end
                R_DIV:
                begin
                    qn_reg  <= {qn_reg[MW-2:0], gen};
                    qd_reg  <= {qd_reg[MW-2:0], ged};
                    rn_reg  <= gen ? MW'(tn - {1'b0, u_reg}) : tn[MW-1:0];
                    rd_reg  <= ged ? MW'(td - {1'b0, u_reg}) : td[MW-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == KW'(MW - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                end
            endcase
        end
    end

    assign done = done_reg;
    assign rnum = qn_reg;
    assign rden = qd_reg;

endmodule

// ===== hw/rtl/min_subset_fraction_product_search.sv =====
// ----------------------------------------------------------------------------
// min_subset_fraction_product_search
// smallest subset of loaded fractions whose product equals a target
// ----------------------------------------------------------------------------
// The block takes one fraction per item and stores up to MAX_ITEMS of them;
// later items of a set are dropped. The item with final_item set starts the
// search, during which no item is taken. Every non-empty subset mask is
// visited in increasing order; the reduced product of a mask is its prefix
// product (mask without its highest bit) times that highest fraction, so
// each mask costs one read of a product memory with 2^MAX_ITEMS entries, two
// multiplies, one reduction, two cross multiplies and one write back. The
// reduction unit (binary gcd followed by a 63-step division) sets the pace:
// a mask whose product is zero skips the gcd, while the gcd loop, which does
// one shift or subtract per iteration, runs longest when magnitudes reach
// 63 bits. A set of n fractions visits 2^n - 1 masks. The final insertion
// sort then walks the loaded fractions and inserts each chosen one among the
// earlier picks by compares, and each result waits for results.ready.
// Results: the chosen fractions as loaded in sorted order, or a single
// not-found or error result (zero denominator, product above 2^63-1).
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module min_subset_fraction_product_search #(
    parameter int MAX_ITEMS   = msfps_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = msfps_pkg::VALUE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    msfps_in_if.sink      items,
    msfps_out_if.source   results,
    msfps_cfg_if.sink     cfg
);

    localparam int VW      = VALUE_WIDTH;
    localparam int MI      = MAX_ITEMS;
    localparam int MW      = msfps_pkg::MAG_W;
    localparam int PW      = MW + VW;
    localparam int EIDX_W  = (MI > 1) ? $clog2(MI) : 1;
    localparam int CNT_W   = $clog2(MI + 1);
    localparam int SIZE_W  = $clog2(MI + 2);
    localparam int PDEPTH  = 1 << MI;
    localparam int PAW     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int PROD_W  = 1 + 2 * MW;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_RD, S_LAT, S_MUL_N, S_MUL_D, S_RED, S_CMP_A, S_CMP_B,
        S_CHECK, S_SORT_SEL, S_SORT_LAT, S_SORT_STEP, S_SORT_CMP, S_EMIT_RD,
        S_EMIT_LAT, S_OUT
    } state_t;

    state_t                 state_reg;

    // target registers
    logic signed [VW-1:0]   tnum_reg, tden_reg;

    // set bookkeeping
    logic [CNT_W-1:0]       loaded_reg;
    logic                   zden_reg;
    logic [MI-1:0]          best_mask_reg;
    logic [SIZE_W-1:0]      best_size_reg;
    logic [MI-1:0]          mask_reg;

    // per mask datapath
    logic                   ps_reg;
    logic [MW-1:0]          pn_in_reg, pd_in_reg;
    logic signed [VW-1:0]   en_reg, ed_reg;
    logic [MW-1:0]          un_reg, ud_reg;
    logic                   neg_reg, s_reg;
    logic [MW-1:0]          rn_reg, rd_reg;
    logic [PW-1:0]          lhs_reg;
    logic                   issued_reg;

    // insertion sort
    logic [CNT_W-1:0]       j_reg, k_reg, cnt_reg;
    logic [EIDX_W-1:0]      sel_reg [MI];
    logic signed [VW-1:0]   cur_n_reg, cur_d_reg;

    // result register
    logic                   ovalid_reg;
    logic [VW-1:0]          on_reg, od_reg;
    msfps_pkg::status_t     st_reg;
    logic                   last_reg;

    // memories
    logic                   e_we;
    logic [EIDX_W-1:0]      e_waddr, e_raddr;
    logic [2*VW-1:0]        e_rdata;
    logic                   p_we;
    logic [PAW-1:0]         p_waddr, p_raddr;
    logic [PROD_W-1:0]      p_wdata, p_rdata;

    // shared units
    logic                   mul_start, mul_done;
    logic [MW-1:0]          mul_a;
    logic [VW-1:0]          mul_b;
    logic [PW-1:0]          mul_p;
    logic                   red_start, red_done;
    logic [MW-1:0]          red_n, red_d;

    logic                   in_acc;
    logic [MI-1:0]          lim, prefix;
    logic [EIDX_W-1:0]      top;
    logic [SIZE_W-1:0]      size;
    logic signed [VW-1:0]   e_num, e_den;
    logic [VW-1:0]          tn_mag, td_mag, en_mag, ed_mag;
    logic signed [2*VW-1:0] sort_l, sort_r;
    logic                   matched;
    logic                   red_sign;

    assign in_acc = items.valid && items.ready;
    assign e_num  = e_rdata[2*VW-1:VW];
    assign e_den  = e_rdata[VW-1:0];

    // masks below 2^n are visited
    assign lim = ~({MI{1'b1}} << loaded_reg);

    always_comb
    begin
        top  = '0;
        size = '0;
        for (int i = 0; i < MI; i++)
        begin
            if (mask_reg[i])
            begin
                top = EIDX_W'(i);
            end
            size = size + SIZE_W'(mask_reg[i]);
        end
        prefix = mask_reg & ~(MI'(1) << top);
    end

    // magnitudes of signed values
    assign tn_mag = tnum_reg[VW-1] ? VW'(-tnum_reg) : VW'(tnum_reg);
    assign td_mag = tden_reg[VW-1] ? VW'(-tden_reg) : VW'(tden_reg);
    assign en_mag = en_reg[VW-1]   ? VW'(-en_reg)   : VW'(en_reg);
    assign ed_mag = ed_reg[VW-1]   ? VW'(-ed_reg)   : VW'(ed_reg);

    // sort compare: a.n * b.d < a.d * b.n
    assign sort_l = cur_n_reg * e_den;
    assign sort_r = cur_d_reg * e_num;

    // product equals target when cross products agree in magnitude and sign
    assign matched = (lhs_reg == mul_p) &&
                     ((lhs_reg == '0) || ((s_reg ^ tden_reg[VW-1]) == tnum_reg[VW-1]));

    assign red_sign = neg_reg && (red_n != '0);

    // multiplier operand select
    always_comb
    begin
        mul_a = pn_in_reg;
        mul_b = en_mag;
        unique case (state_reg)
            S_MUL_D:
            begin
                mul_a = pd_in_reg;
                mul_b = ed_mag;
            end
            S_CMP_A:
            begin
                mul_a = rn_reg;
                mul_b = td_mag;
            end
            S_CMP_B:
            begin
                mul_a = rd_reg;
                mul_b = tn_mag;
            end
            default:
            begin
                mul_a = pn_in_reg;
                mul_b = en_mag;
            end
        endcase
    end

    assign mul_start = !issued_reg && (state_reg == S_MUL_N || state_reg == S_MUL_D ||
                                       state_reg == S_CMP_A || state_reg == S_CMP_B);
    assign red_start = !issued_reg && (state_reg == S_RED);

    // element memory ports
    assign e_we    = in_acc && (loaded_reg < CNT_W'(MI));
    assign e_waddr = loaded_reg[EIDX_W-1:0];

    always_comb
    begin
        e_raddr = top;
        unique case (state_reg)
            S_SORT_SEL:  e_raddr = j_reg[EIDX_W-1:0];
            S_SORT_STEP: e_raddr = sel_reg[k_reg[EIDX_W-1:0] - 1'b1];
            S_EMIT_RD:   e_raddr = sel_reg[k_reg[EIDX_W-1:0]];
            default:     e_raddr = top;
        endcase
    end

    // product memory ports: entry 0 holds 1/1, others written once reduced
    assign p_raddr = PAW'(prefix);
    assign p_we    = (state_reg == S_INIT) || (state_reg == S_RED && red_done);
    assign p_waddr = (state_reg == S_INIT) ? '0 : PAW'(mask_reg);
    assign p_wdata = (state_reg == S_INIT) ? {1'b0, MW'(1), MW'(1)}
                                           : {red_sign, red_n, red_d};

    msfps_ram #(
        .WIDTH (2 * VW),
        .DEPTH (MI)
    ) u_elem_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata ({items.numerator, items.denominator}),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    msfps_ram #(
        .WIDTH (PROD_W),
        .DEPTH (PDEPTH)
    ) u_prod_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    msfps_mul #(
        .BW (VW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    msfps_red u_red (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .num   (un_reg),
        .den   (ud_reg),
        .done  (red_done),
        .rnum  (red_n),
        .rden  (red_d)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tnum_reg <= VW'(1);
            tden_reg <= VW'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (msfps_pkg::cfg_reg_t'(cfg.index))
                msfps_pkg::REG_TARGET_NUM: tnum_reg <= cfg.data;
                msfps_pkg::REG_TARGET_DEN: tden_reg <= cfg.data;
            endcase
        end
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            loaded_reg    <= '0;
            zden_reg      <= 1'b0;
            best_mask_reg <= '0;
            best_size_reg <= SIZE_W'(MI + 1);
            mask_reg      <= '0;
            issued_reg    <= 1'b0;
            ovalid_reg    <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (loaded_reg < CNT_W'(MI))
                        begin
                            loaded_reg <= loaded_reg + 1'b1;
                            if (items.denominator == '0)
                            begin
                                zden_reg <= 1'b1;
                            end
                        end
                        if (items.final_item)
                        begin
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    if (tden_reg == '0 || zden_reg)
                    begin
                        on_reg     <= '0;
                        od_reg     <= '0;
                        st_reg     <= msfps_pkg::ST_ERROR;
                        last_reg   <= 1'b1;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        mask_reg  <= MI'(1);
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_LAT;
                end
                S_LAT:
                begin
                    ps_reg    <= p_rdata[PROD_W-1];
                    pn_in_reg <= p_rdata[2*MW-1:MW];
                    pd_in_reg <= p_rdata[MW-1:0];
                    en_reg    <= e_num;
                    ed_reg    <= e_den;
                    state_reg <= S_MUL_N;
                end
                S_MUL_N, S_MUL_D:
                begin
                    if (!issued_reg)
                    begin
                        issued_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        issued_reg <= 1'b0;
                        if (mul_p[PW-1:MW] != '0)
                        begin
                            // product magnitude above 2^63-1
                            on_reg     <= '0;
                            od_reg     <= '0;
                            st_reg     <= msfps_pkg::ST_ERROR;
                            last_reg   <= 1'b1;
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                        else if (state_reg == S_MUL_N)
                        begin
                            un_reg    <= mul_p[MW-1:0];
                            neg_reg   <= ps_reg ^ en_reg[VW-1] ^ ed_reg[VW-1];
                            state_reg <= S_MUL_D;
                        end
                        else
                        begin
                            ud_reg    <= mul_p[MW-1:0];
                            state_reg <= S_RED;
                        end
                    end
                end
                S_RED:
                begin
                    if (!issued_reg)
                    begin
                        issued_reg <= 1'b1;
                    end
                    else if (red_done)
                    begin
                        issued_reg <= 1'b0;
                        rn_reg     <= red_n;
                        rd_reg     <= red_d;
                        s_reg      <= red_sign;
                        state_reg  <= S_CMP_A;
                    end
                end
                S_CMP_A:
                begin
                    if (!issued_reg)
                    begin
                        issued_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        issued_reg <= 1'b0;
                        lhs_reg    <= mul_p;
                        state_reg  <= S_CMP_B;
                    end
                end
                S_CMP_B:
                begin
                    if (!issued_reg)
                    begin
                        issued_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        issued_reg <= 1'b0;
                        state_reg  <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    // mul_p still holds the second cross product
                    if (matched && size < best_size_reg)
                    begin
                        best_size_reg <= size;
                        best_mask_reg <= mask_reg;
                    end
                    if (mask_reg == lim)
                    begin
                        if (!(matched && size < best_size_reg) &&
                            best_size_reg > SIZE_W'(MI))
                        begin
                            on_reg     <= '0;
                            od_reg     <= '0;
                            st_reg     <= msfps_pkg::ST_NONE;
                            last_reg   <= 1'b1;
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            j_reg     <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_SORT_SEL;
                        end
                    end
                    else
                    begin
                        mask_reg  <= mask_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_SORT_SEL:
                begin
                    if (j_reg == loaded_reg)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else if (best_mask_reg[j_reg[EIDX_W-1:0]])
                    begin
                        state_reg <= S_SORT_LAT;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_SORT_LAT:
                begin
                    cur_n_reg <= e_num;
                    cur_d_reg <= e_den;
                    k_reg     <= cnt_reg;
                    state_reg <= S_SORT_STEP;
                end
                S_SORT_STEP:
                begin
                    if (k_reg == '0)
                    begin
                        sel_reg[0] <= j_reg[EIDX_W-1:0];
                        cnt_reg    <= cnt_reg + 1'b1;
                        j_reg      <= j_reg + 1'b1;
                        state_reg  <= S_SORT_SEL;
                    end
                    else
                    begin
                        state_reg <= S_SORT_CMP;
                    end
                end
                S_SORT_CMP:
                begin
                    if (sort_l < sort_r)
                    begin
                        // move the earlier pick one place up
                        sel_reg[k_reg[EIDX_W-1:0]] <= sel_reg[k_reg[EIDX_W-1:0] - 1'b1];
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= S_SORT_STEP;
                    end
                    else
                    begin
                        sel_reg[k_reg[EIDX_W-1:0]] <= j_reg[EIDX_W-1:0];
                        cnt_reg   <= cnt_reg + 1'b1;
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SORT_SEL;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LAT;
                end
                S_EMIT_LAT:
                begin
                    on_reg     <= e_num;
                    od_reg     <= e_den;
                    st_reg     <= msfps_pkg::ST_FOUND;
                    last_reg   <= (k_reg == cnt_reg - 1'b1);
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_OUT:
                begin
                    if (results.ready)
                    begin
                        ovalid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            // set done, back to loading
                            loaded_reg    <= '0;
                            zden_reg      <= 1'b0;
                            best_mask_reg <= '0;
                            best_size_reg <= SIZE_W'(MI + 1);
                            state_reg     <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
            endcase
        end
    end

    assign items.ready             = (state_reg == S_LOAD);
    assign cfg.ready               = 1'b1;
    assign results.valid           = ovalid_reg;
    assign results.out_numerator   = on_reg;
    assign results.out_denominator = od_reg;
    assign results.status          = st_reg;
    assign results.last_result     = last_reg;

endmodule

// ===== hw/rtl/msfps_checker.sv =====
// ----------------------------------------------------------------------------
// msfps_checker
// port level checks of the subset product search, bound to the top level
// ----------------------------------------------------------------------------
module msfps_checker #(
    parameter int W = msfps_pkg::VALUE_WIDTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [W-1:0]                   out_numerator,
    input logic [W-1:0]                   out_denominator,
    input logic [msfps_pkg::STATUS_W-1:0] status,
    input logic                           last_result
);

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // no item is taken while results of a search are delivered
    a_no_load_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item taken while a result is pending");

    // error and not-found results stand alone with zero fields
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != msfps_pkg::ST_FOUND |->
            last_result && out_numerator == '0 && out_denominator == '0)
        else $error("malformed status result");

endmodule

bind min_subset_fraction_product_search msfps_checker #(
    .W (VALUE_WIDTH)
) u_msfps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (items.ready),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_numerator   (results.out_numerator),
    .out_denominator (results.out_denominator),
    .status          (results.status),
    .last_result     (results.last_result)
);
